[src/rpct_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_pkg: shared types and constants of the RGBA pixel colour transform
// Holds the transaction payload types, the register map, the mode codes and
// the configuration bundle passed from the register file to the datapath.
// ---------------------------------------------------------------------------
package rpct_pkg;

    // Contrast curve geometry: only the lower half of the curve is stored.
    localparam int CURVE_HALF_DEPTH = 128;
    localparam int CURVE_AW         = $clog2(CURVE_HALF_DEPTH);
    localparam int PIX_W            = 8;

    // Configuration port geometry.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Channel slots used for the per-channel curve lookups.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

    // Operation carried by an input transaction.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_TOUCH_FLAGS   = 3'd1;
    localparam logic [2:0] REG_WORD_A        = 3'd2;
    localparam logic [2:0] REG_WORD_B        = 3'd3;
    localparam logic [2:0] REG_GAIN_R        = 3'd4;
    localparam logic [2:0] REG_GAIN_G        = 3'd5;
    localparam logic [2:0] REG_GAIN_B        = 3'd6;
    localparam logic [2:0] REG_BRIGHT_OFFSET = 3'd7;

    // Reset values of the registers.
    localparam logic [16:0] GAIN_UNITY = 17'h10000;

    // Touch-up flag bits.
    localparam int TF_CURVE = 0;
    localparam int TF_MULADD = 1;

    // Transform modes; code 7 carries no meaning and passes pixels through.
    typedef enum logic [2:0] {
        MODE_FADE    = 3'd0,
        MODE_BLEND   = 3'd1,
        MODE_ALPHA   = 3'd2,
        MODE_TOUCH   = 3'd3,
        MODE_GAIN    = 3'd4,
        MODE_REPLACE = 3'd5,
        MODE_KEY     = 3'd6
    } mode_t;

    // Input transaction payload.
    typedef struct packed {
        logic                op;
        logic [PIX_W-1:0]    red_in;
        logic [PIX_W-1:0]    green_in;
        logic [PIX_W-1:0]    blue_in;
        logic [PIX_W-1:0]    alpha_in;
        logic [CURVE_AW-1:0] curve_index;
        logic [PIX_W-1:0]    curve_value;
    } pix_in_t;

    // Output transaction payload.
    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] alpha_out;
    } pix_out_t;

    // Configuration bundle, including the fade level pre-split by 255.
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  touch_flags;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [16:0] gain_r;
        logic [16:0] gain_g;
        logic [16:0] gain_b;
        logic [23:0] bright_offset;
        logic        fade_neg;
        logic [7:0]  fade_quot;
        logic [7:0]  fade_rem;
    } cfg_t;

endpackage
`default_nettype wire

[src/rpct_stream_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_stream_if: valid/ready stream channel
// Carries one payload per transaction; a transaction completes at a rising
// clock edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface rpct_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/rpct_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module rpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/rpct_cfg_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_cfg_regs: configuration register file
// APB-style write and read access to the eight registers. A write of word_a
// also stores the fade level split into quotient and remainder by 255.
// ---------------------------------------------------------------------------
module rpct_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rpct_pkg::APB_AW-1:0] paddr,
    input  wire logic [rpct_pkg::APB_DW-1:0] pwdata,
    output logic      [rpct_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output rpct_pkg::cfg_t                  cfg
);

    rpct_pkg::cfg_t cfg_reg;
    rpct_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    // Split |level| = 255*q + r. Since 256 is 1 modulo 255, r follows from the
    // byte sum, and q modulo 256 from the exact division: q = r - byte0.
    function automatic logic [16:0] fade_split(input logic [31:0] level);
        logic [31:0] mag;
        logic [9:0]  dsum;
        logic [8:0]  fold;
        logic [7:0]  rem;
        logic [7:0]  quot;
        mag  = level[31] ? (~level + 32'd1) : level;
        dsum = 10'(mag[7:0]) + 10'(mag[15:8]) + 10'(mag[23:16]) + 10'(mag[31:24]);
        fold = 9'(dsum[7:0]) + 9'(dsum[9:8]);
        rem  = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
        quot = rem - mag[7:0];
        return {level[31], quot, rem};
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[rpct_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rpct_pkg::REG_MODE:
                    cfg_next.mode = pwdata[2:0];
                rpct_pkg::REG_TOUCH_FLAGS:
                    cfg_next.touch_flags = pwdata[1:0];
                rpct_pkg::REG_WORD_A:
                begin
                    cfg_next.word_a = pwdata;
                    {cfg_next.fade_neg, cfg_next.fade_quot, cfg_next.fade_rem} =
                        fade_split(pwdata);
                end
                rpct_pkg::REG_WORD_B:
                    cfg_next.word_b = pwdata;
                rpct_pkg::REG_GAIN_R:
                    cfg_next.gain_r = pwdata[16:0];
                rpct_pkg::REG_GAIN_G:
                    cfg_next.gain_g = pwdata[16:0];
                rpct_pkg::REG_GAIN_B:
                    cfg_next.gain_b = pwdata[16:0];
                rpct_pkg::REG_BRIGHT_OFFSET:
                    cfg_next.bright_offset = pwdata[23:0];
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{gain_r: rpct_pkg::GAIN_UNITY, gain_g: rpct_pkg::GAIN_UNITY,
                         gain_b: rpct_pkg::GAIN_UNITY, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            rpct_pkg::REG_MODE:          prdata = 32'(cfg_reg.mode);
            rpct_pkg::REG_TOUCH_FLAGS:   prdata = 32'(cfg_reg.touch_flags);
            rpct_pkg::REG_WORD_A:        prdata = cfg_reg.word_a;
            rpct_pkg::REG_WORD_B:        prdata = cfg_reg.word_b;
            rpct_pkg::REG_GAIN_R:        prdata = 32'(cfg_reg.gain_r);
            rpct_pkg::REG_GAIN_G:        prdata = 32'(cfg_reg.gain_g);
            rpct_pkg::REG_GAIN_B:        prdata = 32'(cfg_reg.gain_b);
            rpct_pkg::REG_BRIGHT_OFFSET: prdata = 32'(cfg_reg.bright_offset);
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[src/rpct_curve.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_curve: contrast curve store
// Keeps one RAM copy per colour channel so that three lookups run in the same
// cycle. Valid bits, cleared at reset, make unwritten entries read as zero.
// ---------------------------------------------------------------------------
module rpct_curve (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load_en,
    input  wire logic                lookup_en,
    input  wire rpct_pkg::pix_in_t   pix,
    output logic [rpct_pkg::NUM_CH-1:0][rpct_pkg::PIX_W-1:0] curve_data
);

    localparam int AW = rpct_pkg::CURVE_AW;

    logic [rpct_pkg::CURVE_HALF_DEPTH-1:0] valid_reg;
    logic [rpct_pkg::CURVE_HALF_DEPTH-1:0] valid_next;
    logic [rpct_pkg::NUM_CH-1:0][rpct_pkg::PIX_W-1:0] chan_val;
    logic [rpct_pkg::NUM_CH-1:0][AW-1:0]              rd_addr;
    logic [rpct_pkg::NUM_CH-1:0][rpct_pkg::PIX_W-1:0] rd_data;
    logic [rpct_pkg::NUM_CH-1:0]                      hit_reg;
    logic [rpct_pkg::NUM_CH-1:0]                      hit_next;

    assign chan_val[rpct_pkg::CH_RED]   = pix.red_in;
    assign chan_val[rpct_pkg::CH_GREEN] = pix.green_in;
    assign chan_val[rpct_pkg::CH_BLUE]  = pix.blue_in;

    // Upper-half values look up the mirrored lower-half entry.
    always_comb
    begin
        for (int i = 0; i < rpct_pkg::NUM_CH; i++)
        begin
            rd_addr[i]  = chan_val[i][rpct_pkg::PIX_W-1] ? ~chan_val[i][AW-1:0]
                                                         : chan_val[i][AW-1:0];
            hit_next[i] = valid_reg[rd_addr[i]];
        end
    end

    // Valid bit per entry, set when the entry is loaded.
    always_comb
    begin
        valid_next = valid_reg;
        if (load_en)
        begin
            valid_next[pix.curve_index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Valid flags travel with the registered RAM data.
    always_ff @(posedge clk)
    begin
        if (lookup_en)
        begin
            hit_reg <= hit_next;
        end
    end

    for (genvar i = 0; i < rpct_pkg::NUM_CH; i++)
    begin : g_chan
        rpct_ram #(
            .WIDTH (rpct_pkg::PIX_W),
            .DEPTH (rpct_pkg::CURVE_HALF_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (load_en),
            .waddr (pix.curve_index),
            .wdata (pix.curve_value),
            .re    (lookup_en),
            .raddr (rd_addr[i]),
            .rdata (rd_data[i])
        );

        assign curve_data[i] = hit_reg[i] ? rd_data[i] : '0;
    end

endmodule
`default_nettype wire

[src/rpct_color_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_color_core: per-pixel colour arithmetic
// Combinational transform of one registered pixel in the configured mode,
// using the curve entries fetched when the pixel was accepted.
// ---------------------------------------------------------------------------
module rpct_color_core (
    input  wire rpct_pkg::cfg_t    cfg,
    input  wire rpct_pkg::pix_in_t pix,
    input  wire logic [rpct_pkg::NUM_CH-1:0][rpct_pkg::PIX_W-1:0] curve_data,
    output rpct_pkg::pix_out_t     result
);

    logic [rpct_pkg::NUM_CH-1:0][7:0]  chan;
    logic [rpct_pkg::NUM_CH-1:0][16:0] gain;
    logic [rpct_pkg::NUM_CH-1:0][7:0]  res;
    logic [7:0]                        alpha;
    logic                              alpha_nz;
    logic [33:0]                       alpha_sum;

    // Fade: c*level/255 from the pre-split level, truncated toward zero.
    function automatic logic [7:0] fade_ch(input logic [7:0] c, input logic [7:0] quot,
                                           input logic [7:0] rem, input logic neg);
        logic [15:0] prod_r;
        logic [16:0] t1;
        logic [16:0] t2;
        logic [15:0] prod_q;
        logic [7:0]  mag;
        prod_r = 16'(c) * 16'(rem);
        // Exact floor division by 255 for the small remainder product.
        t1     = 17'(prod_r) + 17'd1;
        t2     = t1 + (t1 >> 8);
        prod_q = 16'(c) * 16'(quot);
        mag    = prod_q[7:0] + t2[15:8];
        return neg ? 8'(~mag + 8'd1) : mag;
    endfunction

    // Q16 multiply-add with saturation at 255.
    function automatic logic [7:0] mul_ch(input logic [7:0] v, input logic [16:0] g,
                                          input logic [23:0] add);
        logic [25:0] acc;
        acc = 26'(g) * 26'(v) + 26'(add);
        return (|acc[25:24]) ? 8'hFF : acc[23:16];
    endfunction

    // Touch-up: optional mirrored curve, then optional multiply-add.
    function automatic logic [7:0] touch_ch(input logic [7:0] c, input logic [7:0] crv,
                                            input rpct_pkg::cfg_t cf);
        logic [7:0] v;
        v = c;
        if (cf.touch_flags[rpct_pkg::TF_CURVE])
        begin
            v = c[7] ? ~crv : crv;
        end
        if (cf.touch_flags[rpct_pkg::TF_MULADD])
        begin
            v = mul_ch(v, cf.gain_r, cf.bright_offset);
        end
        return v;
    endfunction

    assign chan[rpct_pkg::CH_RED]   = pix.red_in;
    assign chan[rpct_pkg::CH_GREEN] = pix.green_in;
    assign chan[rpct_pkg::CH_BLUE]  = pix.blue_in;
    assign gain[rpct_pkg::CH_RED]   = cfg.gain_r;
    assign gain[rpct_pkg::CH_GREEN] = cfg.gain_g;
    assign gain[rpct_pkg::CH_BLUE]  = cfg.gain_b;
    assign alpha_nz                 = (pix.alpha_in != '0);

    // Signed alpha offset, wide enough for any 32-bit offset.
    assign alpha_sum = {26'd0, pix.alpha_in} + {{2{cfg.word_a[31]}}, cfg.word_a};

    // Mode selection.
    always_comb
    begin
        res   = chan;
        alpha = pix.alpha_in;
        unique case (cfg.mode)
            rpct_pkg::MODE_FADE:
            begin
                for (int i = 0; i < rpct_pkg::NUM_CH; i++)
                begin
                    res[i] = fade_ch(chan[i], cfg.fade_quot, cfg.fade_rem, cfg.fade_neg);
                end
            end
            rpct_pkg::MODE_BLEND:
            begin
                for (int i = 0; i < rpct_pkg::NUM_CH; i++)
                begin
                    res[i] = 8'((9'(cfg.word_a[(2-i)*8 +: 8]) + 9'(chan[i])) >> 1);
                end
            end
            rpct_pkg::MODE_ALPHA:
            begin
                if (alpha_nz)
                begin
                    if (alpha_sum[33])
                        alpha = 8'h00;
                    else if (|alpha_sum[32:8])
                        alpha = 8'hFF;
                    else
                        alpha = alpha_sum[7:0];
                end
            end
            rpct_pkg::MODE_TOUCH:
            begin
                for (int i = 0; i < rpct_pkg::NUM_CH; i++)
                begin
                    res[i] = touch_ch(chan[i], curve_data[i], cfg);
                end
            end
            rpct_pkg::MODE_GAIN:
            begin
                if (alpha_nz)
                begin
                    for (int i = 0; i < rpct_pkg::NUM_CH; i++)
                    begin
                        res[i] = mul_ch(chan[i], gain[i], 24'd0);
                    end
                end
            end
            rpct_pkg::MODE_REPLACE:
            begin
                if ({pix.alpha_in, pix.red_in, pix.green_in, pix.blue_in} == cfg.word_a)
                begin
                    res[rpct_pkg::CH_RED]   = cfg.word_b[23:16];
                    res[rpct_pkg::CH_GREEN] = cfg.word_b[15:8];
                    res[rpct_pkg::CH_BLUE]  = cfg.word_b[7:0];
                    alpha                   = cfg.word_b[31:24];
                end
            end
            rpct_pkg::MODE_KEY:
            begin
                // All ones in the key word forces every pixel opaque.
                if (cfg.word_a != 32'hFFFF_FFFF &&
                    {pix.red_in, pix.green_in, pix.blue_in} == cfg.word_a[23:0])
                    alpha = 8'h00;
                else
                    alpha = 8'hFF;
            end
            default:
            begin
                // Undefined mode: the pixel passes unchanged.
            end
        endcase
    end

    assign result.red_out   = res[rpct_pkg::CH_RED];
    assign result.green_out = res[rpct_pkg::CH_GREEN];
    assign result.blue_out  = res[rpct_pkg::CH_BLUE];
    assign result.alpha_out = alpha;

endmodule
`default_nettype wire

[src/rgba_pixel_color_transform_unit.sv]
`default_nettype none
// Path: an accepted pixel goes from the input register to the result register and
// leaves from there when the result side is ready; curve loads give no result.
// Throughput: one transaction per cycle when results flow, set by the input register,
// the registered per-channel curve RAM read at acceptance and the result register.
// Reset: asynchronous, active low; registers take their reset values and curve valid
// bits clear at once, so the curve reads as zero with no clearing pass.
// ---------------------------------------------------------------------------
// rgba_pixel_color_transform_unit: RGBA pixel colour transform
// Streams pixels through an input register and a result register, with the
// configured transform between them and an APB-style register port.
// ---------------------------------------------------------------------------
module rgba_pixel_color_transform_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rpct_pkg::APB_AW-1:0] paddr,
    input  wire logic [rpct_pkg::APB_DW-1:0] pwdata,
    output logic      [rpct_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    rpct_stream_if.sink                      pixels,
    rpct_stream_if.source                    results
);

    rpct_pkg::cfg_t     cfg;
    rpct_pkg::pix_out_t core_result;
    logic [rpct_pkg::NUM_CH-1:0][rpct_pkg::PIX_W-1:0] curve_data;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    rpct_pkg::pix_in_t  s1_pix_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    rpct_pkg::pix_out_t out_pix_reg;

    logic out_free;
    logic in_accept;
    logic pix_accept;
    logic load_accept;

    // Handshake: the result register frees the input register when it moves on.
    assign out_free    = !out_valid_reg || results.ready;
    assign pixels.ready = !s1_valid_reg || out_free;
    assign in_accept   = pixels.valid && pixels.ready;
    assign pix_accept  = in_accept && (pixels.payload.op == rpct_pkg::OP_PIXEL);
    assign load_accept = in_accept && (pixels.payload.op == rpct_pkg::OP_LOAD);

    rpct_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpct_curve u_curve (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_accept),
        .lookup_en  (pix_accept),
        .pix        (pixels.payload),
        .curve_data (curve_data)
    );

    rpct_color_core u_core (
        .cfg        (cfg),
        .pix        (s1_pix_reg),
        .curve_data (curve_data),
        .result     (core_result)
    );

    // Valid flags of the two pipeline registers.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (pix_accept)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        if (out_free)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
            s1_pix_reg <= pixels.payload;
        if (out_free && s1_valid_reg)
            out_pix_reg <= core_result;
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_pix_reg;

endmodule
`default_nettype wire

[sim/rgba_pixel_color_transform_unit_test.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rgba_pixel_color_transform_unit_test: self-checking bench for the colour unit
// Loads each transform mode through the register port and streams pixels and
// contrast curve loads with random bursts and result stalls. A predictor in
// the bench recolours every accepted pixel, and the monitor compares each
// result channel by channel with the oldest prediction.
// ---------------------------------------------------------------------------
module rgba_pixel_color_transform_unit_test;
    import rpct_pkg::*;

    // Code 7 has no transform of its own and passes pixels through.
    localparam logic [2:0] MODE_PASS = 3'd7;

    localparam int NUM_PHASES    = 18;
    localparam int RANDOM_PIXELS = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 1000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    rpct_stream_if #(.payload_t(pix_in_t))  pix_if ();
    rpct_stream_if #(.payload_t(pix_out_t)) res_if ();

    rgba_pixel_color_transform_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixels  (pix_if),
        .results (res_if)
    );

    // Shadow copy of the register file and the lower half of the curve.
    logic [2:0]  cfg_mode          = MODE_FADE;
    logic [1:0]  cfg_touch_flags   = '0;
    logic [31:0] cfg_word_a        = '0;
    logic [31:0] cfg_word_b        = '0;
    logic [16:0] cfg_gain_r        = GAIN_UNITY;
    logic [16:0] cfg_gain_g        = GAIN_UNITY;
    logic [16:0] cfg_gain_b        = GAIN_UNITY;
    logic [23:0] cfg_bright_offset = '0;
    logic [7:0]  curve_shadow [CURVE_HALF_DEPTH] = '{default: 8'h00};

    pix_in_t     input_backlog [$];
    pix_out_t    expected_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles;

    // Sender burst state and receiver stall pattern.
    int unsigned burst_left;
    int unsigned gap_left;
    logic [15:0] ready_pattern;
    logic [3:0]  pattern_pos;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    function automatic logic [7:0] clamp_u8(input longint v);
        if (v < 0)
            return 8'h00;
        if (v > 255)
            return 8'hFF;
        return v[7:0];
    endfunction

    // Signed level times channel over 255, truncated towards zero.
    function automatic logic [7:0] fade_chan(input logic [7:0] c);
        longint q;
        q = longint'(c) * longint'($signed(cfg_word_a));
        q = q / 255;
        return q[7:0];
    endfunction

    function automatic logic [7:0] blend_chan(input logic [7:0] w, input logic [7:0] c);
        logic [8:0] s;
        s = w + c;
        return s[8:1];
    endfunction

    function automatic logic [7:0] gain_chan(input logic [7:0] c, input logic [16:0] g);
        logic [24:0] prod;
        prod = g * c;
        return clamp_u8(longint'(prod >> 16));
    endfunction

    // Mirrored contrast curve followed by the Q16 multiply-add.
    function automatic logic [7:0] touch_chan(input logic [7:0] c);
        logic [7:0]  v;
        logic [25:0] acc;
        v = c;
        if (cfg_touch_flags[TF_CURVE])
            v = (v < CURVE_HALF_DEPTH) ? curve_shadow[v[6:0]] : 8'hFF - curve_shadow[~v[6:0]];
        if (cfg_touch_flags[TF_MULADD])
        begin
            acc = cfg_gain_r * v + cfg_bright_offset;
            v   = clamp_u8(longint'(acc >> 16));
        end
        return v;
    endfunction

    function automatic pix_out_t recolour_pixel(input pix_in_t px);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        pix_out_t   res;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        a = px.alpha_in;
        case (cfg_mode)
            MODE_FADE:
            begin
                r = fade_chan(r);
                g = fade_chan(g);
                b = fade_chan(b);
            end
            MODE_BLEND:
            begin
                r = blend_chan(cfg_word_a[23:16], r);
                g = blend_chan(cfg_word_a[15:8], g);
                b = blend_chan(cfg_word_a[7:0], b);
            end
            MODE_ALPHA:
            begin
                if (a != 8'h00)
                    a = clamp_u8(longint'(a) + longint'($signed(cfg_word_a)));
            end
            MODE_TOUCH:
            begin
                r = touch_chan(r);
                g = touch_chan(g);
                b = touch_chan(b);
            end
            MODE_GAIN:
            begin
                if (a != 8'h00)
                begin
                    r = gain_chan(r, cfg_gain_r);
                    g = gain_chan(g, cfg_gain_g);
                    b = gain_chan(b, cfg_gain_b);
                end
            end
            MODE_REPLACE:
            begin
                if ({a, r, g, b} == cfg_word_a)
                    {a, r, g, b} = cfg_word_b;
            end
            MODE_KEY:
            begin
                if (cfg_word_a == 32'hFFFF_FFFF)
                    a = 8'hFF;
                else if ({r, g, b} == cfg_word_a[23:0])
                    a = 8'h00;
                else
                    a = 8'hFF;
            end
            default:
            begin
            end
        endcase
        res.red_out   = r;
        res.green_out = g;
        res.blue_out  = b;
        res.alpha_out = a;
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Reporting
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %02h, expected %02h", name, got, want));
    endtask

    // -----------------------------------------------------------------------
    // Pixel driver: bursts of random length with random gaps between them.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid   <= 1'b0;
            pix_if.payload <= '0;
            burst_left     <= 0;
            gap_left       <= 0;
        end
        else
        begin
            // An accepted transaction updates the curve copy or is predicted.
            if (pix_if.valid && pix_if.ready)
            begin
                if (pix_if.payload.op == OP_LOAD)
                    curve_shadow[pix_if.payload.curve_index] = pix_if.payload.curve_value;
                else
                    expected_pixels.push_back(recolour_pixel(pix_if.payload));
            end

            // A stalled transaction is held; otherwise idle or offer the next one.
            if (!pix_if.valid || pix_if.ready)
            begin
                if (gap_left != 0)
                begin
                    pix_if.valid <= 1'b0;
                    gap_left     <= gap_left - 1;
                end
                else if (input_backlog.size() != 0)
                begin
                    pix_if.valid   <= 1'b1;
                    pix_if.payload <= input_backlog.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: checks each transaction and stalls on a rolling pattern.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            res_if.ready  <= 1'b0;
            ready_pattern <= '1;
            pattern_pos   <= '0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("result transaction with no pixel outstanding");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("red",   res_if.payload.red_out,   want.red_out);
                    check_channel("green", res_if.payload.green_out, want.green_out);
                    check_channel("blue",  res_if.payload.blue_out,  want.blue_out);
                    check_channel("alpha", res_if.payload.alpha_out, want.alpha_out);
                end
            end

            // Bit 0 is always set, so no stall lasts longer than one pattern.
            res_if.ready <= ready_pattern[pattern_pos];
            pattern_pos  <= pattern_pos + 1'b1;
            if (pattern_pos == 4'hF)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= '1;
                    1:       ready_pattern <= 16'($urandom) | 16'h0001;
                    default: ready_pattern <= 16'($urandom) | 16'($urandom) | 16'h0001;
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR at %0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:          cfg_mode          = val[2:0];
            REG_TOUCH_FLAGS:   cfg_touch_flags   = val[1:0];
            REG_WORD_A:        cfg_word_a        = val;
            REG_WORD_B:        cfg_word_b        = val;
            REG_GAIN_R:        cfg_gain_r        = val[16:0];
            REG_GAIN_G:        cfg_gain_g        = val[16:0];
            REG_GAIN_B:        cfg_gain_b        = val[16:0];
            REG_BRIGHT_OFFSET: cfg_bright_offset = val[23:0];
            default:
            begin
            end
        endcase
    endtask

    // Waits until every transaction has gone through and the pipeline is quiet.
    task automatic wait_idle();
        @(negedge clk);
        while (input_backlog.size() != 0 || pix_if.valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        pix_in_t it;
        it.op          = OP_PIXEL;
        it.red_in      = r;
        it.green_in    = g;
        it.blue_in     = b;
        it.alpha_in    = a;
        it.curve_index = CURVE_AW'($urandom_range(0, CURVE_HALF_DEPTH - 1));
        it.curve_value = 8'($urandom_range(0, 255));
        input_backlog.push_back(it);
    endtask

    task automatic send_load(input logic [6:0] idx, input logic [7:0] val);
        pix_in_t it;
        it             = '0;
        it.op          = OP_LOAD;
        it.curve_index = idx;
        it.curve_value = val;
        input_backlog.push_back(it);
    endtask

    // Channel values biased towards the extremes and the curve mirror point.
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'h1FFFF;
            2:       return 32'(GAIN_UNITY);
            default: return $urandom_range(0, 32'h1FFFF);
        endcase
    endfunction

    // Random transaction shaped by the current mode: matching colours for
    // replace and key, transparent pixels for alpha and gain, curve loads
    // mostly in touch-up.
    function automatic pix_in_t make_item();
        pix_in_t     it;
        logic [31:0] argb;
        int unsigned load_pct;
        it.op          = OP_PIXEL;
        it.red_in      = rand_chan();
        it.green_in    = rand_chan();
        it.blue_in     = rand_chan();
        it.alpha_in    = rand_chan();
        it.curve_index = CURVE_AW'($urandom_range(0, CURVE_HALF_DEPTH - 1));
        it.curve_value = rand_chan();
        load_pct       = (cfg_mode == MODE_TOUCH) ? 25 : 4;
        if ($urandom_range(0, 99) < load_pct)
        begin
            it.op = OP_LOAD;
            return it;
        end
        case (cfg_mode)
            MODE_REPLACE:
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    argb = cfg_word_a;
                    // Near misses differ from the match colour in one bit.
                    if ($urandom_range(0, 3) == 0)
                        argb = argb ^ (32'h1 << $urandom_range(0, 31));
                    {it.alpha_in, it.red_in, it.green_in, it.blue_in} = argb;
                end
            end
            MODE_KEY:
            begin
                if ($urandom_range(0, 9) < 4)
                    {it.red_in, it.green_in, it.blue_in} = cfg_word_a[23:0];
            end
            MODE_ALPHA, MODE_GAIN:
            begin
                if ($urandom_range(0, 4) == 0)
                    it.alpha_in = 8'h00;
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    // One random phase: configure every register, then stream with a full
    // drain halfway through.
    task automatic run_phase(input logic [2:0] m, input logic [1:0] flags,
                             input int n_pixels);
        logic [31:0] wa;
        int          sent;
        pix_in_t     it;
        wait_idle();
        case (m)
            MODE_FADE:
            begin
                case ($urandom_range(0, 5))
                    0:       wa = 32'd0;
                    1:       wa = 32'd255;
                    2:       wa = $urandom_range(0, 255);
                    3:       wa = 32'hFFFF_FFFF;
                    4:       wa = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: wa = $urandom;
                endcase
            end
            MODE_ALPHA:
            begin
                case ($urandom_range(0, 3))
                    0:       wa = 32'h8000_0000;
                    1:       wa = 32'h7FFF_FFFF;
                    2:       wa = $urandom;
                    default: wa = 32'(int'($urandom_range(0, 600)) - 300);
                endcase
            end
            MODE_KEY:
            begin
                wa = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
            end
            default:
            begin
                wa = $urandom;
            end
        endcase
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_TOUCH_FLAGS, 32'(flags));
        write_reg(REG_WORD_A, wa);
        write_reg(REG_WORD_B, $urandom);
        write_reg(REG_GAIN_R, pick_gain());
        write_reg(REG_GAIN_G, pick_gain());
        write_reg(REG_GAIN_B, pick_gain());
        write_reg(REG_BRIGHT_OFFSET, ($urandom_range(0, 3) == 0) ?
                  32'h00FF_0000 : $urandom_range(0, 32'h00FF_0000));
        sent = 0;
        while (sent < n_pixels)
        begin
            it = make_item();
            input_backlog.push_back(it);
            if (it.op == OP_PIXEL)
            begin
                sent++;
                if (sent == n_pixels / 2)
                    wait_idle();
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [2:0] phase_modes [NUM_PHASES];
        logic [1:0] touch_count;

        phase_modes = '{MODE_FADE, MODE_BLEND, MODE_ALPHA, MODE_TOUCH, MODE_GAIN,
                        MODE_REPLACE, MODE_KEY, MODE_PASS, MODE_TOUCH, MODE_FADE,
                        MODE_TOUCH, MODE_GAIN, MODE_ALPHA, MODE_KEY, MODE_REPLACE,
                        MODE_TOUCH, MODE_BLEND, MODE_FADE};
        touch_count    = '0;

        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: fade with level zero clears the colour channels.
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);

        // Touch-up on the cleared curve, then after loading both ends of it.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_TOUCH));
        write_reg(REG_TOUCH_FLAGS, 32'(1 << TF_CURVE));
        send_pixel(8'h00, 8'h7F, 8'h80, 8'h5A);
        send_load(7'd0, 8'hFF);
        send_load(7'd127, 8'h80);
        send_pixel(8'h00, 8'h7F, 8'h80, 8'hFF);
        send_pixel(8'hFF, 8'h40, 8'hC0, 8'h00);

        // Multiply-add at full gain and offset saturates.
        wait_idle();
        write_reg(REG_TOUCH_FLAGS, 32'((1 << TF_CURVE) | (1 << TF_MULADD)));
        write_reg(REG_GAIN_R, 32'h1FFFF);
        write_reg(REG_BRIGHT_OFFSET, 32'h00FF_0000);
        send_pixel(8'hFF, 8'h00, 8'h80, 8'h11);

        // Fade at unity, most negative and minus one.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_FADE));
        write_reg(REG_WORD_A, 32'd255);
        send_pixel(8'hFF, 8'h01, 8'h80, 8'h33);
        wait_idle();
        write_reg(REG_WORD_A, 32'h8000_0000);
        send_pixel(8'hFF, 8'h01, 8'h80, 8'h33);
        wait_idle();
        write_reg(REG_WORD_A, 32'hFFFF_FFFF);
        send_pixel(8'hFF, 8'h01, 8'h80, 8'h33);

        // Blend towards white.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_BLEND));
        send_pixel(8'h00, 8'hFF, 8'h80, 8'hC3);

        // Alpha offset: transparent pixels stay transparent, others clamp.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_ALPHA));
        write_reg(REG_WORD_A, 32'hFFFF_FF00);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h00);
        send_pixel(8'h12, 8'h34, 8'h56, 8'hFF);
        wait_idle();
        write_reg(REG_WORD_A, 32'h7FFF_FFFF);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h01);

        // Channel gain: transparent pixels untouched, saturation at full gain.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_GAIN));
        write_reg(REG_GAIN_G, 32'h0);
        write_reg(REG_GAIN_B, 32'(GAIN_UNITY));
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01);

        // Replace: exact match, and a miss in alpha only.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_REPLACE));
        write_reg(REG_WORD_A, 32'h8040_2010);
        write_reg(REG_WORD_B, 32'h0102_0304);
        send_pixel(8'h40, 8'h20, 8'h10, 8'h80);
        send_pixel(8'h40, 8'h20, 8'h10, 8'h81);

        // Colour key: all ones forces opaque, otherwise the key goes clear.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_KEY));
        write_reg(REG_WORD_A, 32'hFFFF_FFFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_WORD_A, 32'h0012_3456);
        send_pixel(8'h12, 8'h34, 8'h56, 8'hFF);
        send_pixel(8'h12, 8'h34, 8'h57, 8'h00);

        // Code with no transform passes the pixel through.
        wait_idle();
        write_reg(REG_MODE, 32'(MODE_PASS));
        send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);

        // Random phases over every mode and every touch-up flag setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            run_phase(phase_modes[p], touch_count, RANDOM_PIXELS / NUM_PHASES);
            if (phase_modes[p] == MODE_TOUCH)
                touch_count = touch_count + 1'b1;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[rgba_pixel_color_transform_unit.f]
src/rpct_pkg.sv
src/rpct_stream_if.sv
src/rpct_ram.sv
src/rpct_cfg_regs.sv
src/rpct_curve.sv
src/rpct_color_core.sv
src/rgba_pixel_color_transform_unit.sv
sim/rgba_pixel_color_transform_unit_test.sv
